@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/pdlru_pkg.sv @@
// Shared constants, types and helpers of the per-die LRU buffer allocator.
package pdlru_pkg;

    localparam int DIES            = 64;
    localparam int ENTRIES_PER_DIE = 16;
    localparam int TOTAL_ENTRIES   = DIES * ENTRIES_PER_DIE;

    localparam int DIE_W   = 6;
    localparam int ENTRY_W = 10;
    localparam int TAG_W   = 8;
    localparam int LINK_W  = ENTRY_W + 1;
    localparam int BASE_W  = ENTRY_W + 1;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ENTRY_W - TAG_W;

    localparam logic [LINK_W-1:0] LINK_NONE = '1;

    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_ATTACH = 1'b1;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [LINK_W-1:0]  t_link;
    typedef logic [TAG_W-1:0]   t_tag;
    typedef logic [DIE_W-1:0]   t_die;

    typedef struct packed {
        t_entry head;
        t_entry tail;
    } t_head_tail;

    typedef struct packed {
        logic valid;
        t_tag tag;
    } t_blocker;

    typedef struct packed {
        t_entry buffer_entry;
        logic   had_blocker;
        t_tag   prior_tag;
    } t_result;

    function automatic logic link_ok(input t_link v);
        return 32'(v) < TOTAL_ENTRIES;
    endfunction

    function automatic logic entry_ok(input t_entry v);
        return 32'(v) < TOTAL_ENTRIES;
    endfunction

    function automatic logic die_ok(input t_die v);
        return 32'(v) < DIES;
    endfunction

endpackage

@@ hw/rtl/pdlru_out_stage.sv @@
// Output register of the allocator: holds one result until the sink takes it.
module pdlru_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  pdlru_pkg::t_result i_res,
    input  logic               i_ready,
    output logic               o_free,
    output logic               o_valid,
    output pdlru_pkg::t_result o_res
);

    logic               r_valid;
    pdlru_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ hw/rtl/per_die_lru_buffer_allocator.sv @@
// Top level of the per-die LRU buffer allocator.
// After reset the block sweeps its memories, one entry per cycle, to build each die's recency
// list in index order and clear all blocker tags; s_axis_tready stays low during the sweep.
// It then works on one request at a time. An attach reads and then writes the blocker memory.
// An allocate reads the head/tail memory, then the prev link of the tail, and then writes the
// prev links one at a time, since the link memory has a single write port: the victim's first
// and, when the die's list has more than one entry, the old head's after it. When the output
// register is still full as a request finishes, the request waits in a hold state until the
// sink takes the pending result.
module per_die_lru_buffer_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // die[5:0], entry[15:6], req_tag[23:16]
    input  logic [pdlru_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // buffer_entry[9:0], prior_tag[17:10], zero[23:18]
    output logic [pdlru_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // had_blocker
    output logic                              m_axis_tuser
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_AL_RD  = 3'd2;
    localparam logic [2:0] S_AL_WR1 = 3'd3;
    localparam logic [2:0] S_AL_WR2 = 3'd4;
    localparam logic [2:0] S_AT_WR  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam int DW = pdlru_pkg::DIE_W;
    localparam int EW = pdlru_pkg::ENTRY_W;
    localparam int TW = pdlru_pkg::TAG_W;

    // memories
    pdlru_pkg::t_head_tail hl_mem   [pdlru_pkg::DIES];
    pdlru_pkg::t_link      prev_mem [pdlru_pkg::TOTAL_ENTRIES];
    pdlru_pkg::t_blocker   blk_mem  [pdlru_pkg::TOTAL_ENTRIES];

    pdlru_pkg::t_head_tail r_hl_rd;
    pdlru_pkg::t_link      r_prev_rd;
    pdlru_pkg::t_blocker   r_blk_rd;

    logic [2:0]                     r_state, n_state;
    pdlru_pkg::t_die                r_die;
    pdlru_pkg::t_entry              r_entry;
    pdlru_pkg::t_tag                r_tag;
    pdlru_pkg::t_entry              r_victim, n_victim;
    pdlru_pkg::t_entry              r_old_head, n_old_head;
    pdlru_pkg::t_result             r_res, n_res;
    pdlru_pkg::t_entry              r_clr_idx;
    logic [pdlru_pkg::BASE_W-1:0]   r_clr_base;
    pdlru_pkg::t_die                r_clr_die;

    logic                  hl_we;
    pdlru_pkg::t_die       hl_waddr;
    pdlru_pkg::t_head_tail hl_wdata;
    logic                  prev_we;
    pdlru_pkg::t_entry     prev_waddr;
    pdlru_pkg::t_link      prev_wdata;
    logic                  blk_we;
    pdlru_pkg::t_entry     blk_waddr;
    pdlru_pkg::t_blocker   blk_wdata;

    logic               s_accept;
    logic               clr_first;
    logic               res_load;
    logic               out_free;
    pdlru_pkg::t_result out_res;
    pdlru_pkg::t_entry  in_entry;
    pdlru_pkg::t_die    in_die;

    assign in_die    = s_axis_tdata[DW-1:0];
    assign in_entry  = s_axis_tdata[DW+EW-1:DW];
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign clr_first = ({1'b0, r_clr_idx} == r_clr_base);

    // memory ports, read data registered
    always_ff @(posedge i_clk) begin
        if (hl_we) begin
            hl_mem[hl_waddr] <= hl_wdata;
        end
        r_hl_rd <= hl_mem[in_die];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        r_prev_rd <= prev_mem[r_hl_rd.tail];
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        r_blk_rd <= blk_mem[in_entry];
    end

    always_comb begin
        n_state    = r_state;
        n_victim   = r_victim;
        n_old_head = r_old_head;
        n_res      = r_res;
        res_load   = 1'b0;
        hl_we      = 1'b0;
        hl_waddr   = r_die;
        hl_wdata   = r_hl_rd;
        prev_we    = 1'b0;
        prev_waddr = r_victim;
        prev_wdata = pdlru_pkg::LINK_NONE;
        blk_we     = 1'b0;
        blk_waddr  = r_entry;
        blk_wdata  = '{valid: 1'b1, tag: r_tag};

        unique case (r_state)
            S_CLEAR: begin
                // build each die's chain in index order and clear blockers
                prev_we    = 1'b1;
                prev_waddr = r_clr_idx;
                prev_wdata = clr_first ? pdlru_pkg::LINK_NONE
                                       : {1'b0, r_clr_idx - EW'(1)};
                blk_we     = 1'b1;
                blk_waddr  = r_clr_idx;
                blk_wdata  = '{valid: 1'b0, tag: '0};
                hl_we      = clr_first;
                hl_waddr   = r_clr_die;
                hl_wdata.head = r_clr_idx;
                hl_wdata.tail = EW'(32'(r_clr_idx) + pdlru_pkg::ENTRIES_PER_DIE - 1);
                if (r_clr_idx == EW'(pdlru_pkg::TOTAL_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_state = (s_axis_tuser == pdlru_pkg::KIND_ATTACH) ? S_AT_WR : S_AL_RD;
                end
            end
            S_AL_RD: begin
                n_victim   = r_hl_rd.tail;
                n_old_head = r_hl_rd.head;
                if (!pdlru_pkg::die_ok(r_die) ||
                    !pdlru_pkg::link_ok({1'b0, r_hl_rd.tail})) begin
                    n_res   = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_AL_WR1;
                end
            end
            S_AL_WR1: begin
                prev_we    = 1'b1;
                prev_waddr = r_victim;
                prev_wdata = pdlru_pkg::LINK_NONE;
                hl_we      = 1'b1;
                hl_wdata.head = r_victim;
                hl_wdata.tail = pdlru_pkg::link_ok(r_prev_rd) ? r_prev_rd[EW-1:0] : r_victim;
                n_res = '{buffer_entry: r_victim, had_blocker: 1'b0, prior_tag: '0};
                if (pdlru_pkg::link_ok(r_prev_rd) &&
                    pdlru_pkg::link_ok({1'b0, r_old_head})) begin
                    n_state = S_AL_WR2;
                end else begin
                    res_load = 1'b1;
                end
            end
            S_AL_WR2: begin
                prev_we    = 1'b1;
                prev_waddr = r_old_head;
                prev_wdata = {1'b0, r_victim};
                res_load   = 1'b1;
            end
            S_AT_WR: begin
                n_res = '{buffer_entry: r_entry, had_blocker: 1'b0, prior_tag: '0};
                if (pdlru_pkg::entry_ok(r_entry)) begin
                    blk_we = 1'b1;
                    if (r_blk_rd.valid) begin
                        n_res.had_blocker = 1'b1;
                        n_res.prior_tag   = r_blk_rd.tag;
                    end
                end
                res_load = 1'b1;
            end
            S_OUT: begin
                res_load = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result over, or hold it until the output register frees up
        if (res_load) begin
            n_state = out_free ? S_IDLE : S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_idx  <= '0;
            r_clr_base <= '0;
            r_clr_die  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + EW'(1);
                if (clr_first) begin
                    r_clr_base <= pdlru_pkg::BASE_W'(32'(r_clr_base)
                                                     + pdlru_pkg::ENTRIES_PER_DIE);
                    r_clr_die  <= r_clr_die + DW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_die   <= in_die;
            r_entry <= in_entry;
            r_tag   <= s_axis_tdata[DW+EW+TW-1:DW+EW];
        end
        r_victim   <= n_victim;
        r_old_head <= n_old_head;
        r_res      <= n_res;
    end

    pdlru_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (n_res),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {{pdlru_pkg::OUT_PAD_W{1'b0}}, out_res.prior_tag, out_res.buffer_entry};
    assign m_axis_tuser = out_res.had_blocker;

endmodule

@@ hw/rtl/pdlru_checker.sv @@
// Port-level checks of the per-die LRU buffer allocator, bound to its top level.
`include "assert_macros.svh"

module pdlru_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [pdlru_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pdlru_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                              m_axis_tuser
);

    localparam int TAG_LO = pdlru_pkg::ENTRY_W;
    localparam int TAG_HI = pdlru_pkg::ENTRY_W + pdlru_pkg::TAG_W - 1;

    logic in_acc;
    logic unused_in;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign unused_in = ^{s_axis_tdata, s_axis_tuser};

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one request at a time: ready drops right after a request is taken
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_acc, !s_axis_tready)

    // no result appears in the cycle right after a request is taken
    `ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, in_acc && !m_axis_tvalid,
        !m_axis_tvalid)

    // prior tag reads zero unless a blocker was found
    `ASSERT_SAME(a_tag_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[TAG_HI:TAG_LO] == '0)

    // padding bits stay zero
    `ASSERT_SAME(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[pdlru_pkg::OUT_TDATA_W-1:TAG_HI+1] == '0)

endmodule

bind per_die_lru_buffer_allocator pdlru_checker u_pdlru_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
